@@ rtl/teaq_pkg.sv @@
// shared types and constants of the timed evidence alarm qualifier
package teaq_pkg;

    // entry levels
    localparam logic [1:0] LVL_NORMAL    = 2'd0;
    localparam logic [1:0] LVL_CANDIDATE = 2'd1;
    localparam logic [1:0] LVL_ALERT     = 2'd2;

    // operations
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // threshold kinds
    localparam logic [1:0] KIND_MULTI_PERSON = 2'd0;
    localparam logic [1:0] KIND_PHONE        = 2'd1;

    // configuration register indexes
    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE_HOLD = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MULTI_PERSON = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHONE        = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINGERING    = 8'd3;

    localparam logic [31:0] RELEASE_HOLD_RESET = 32'd2000;
    localparam logic [31:0] MULTI_PERSON_RESET = 32'd3000;
    localparam logic [31:0] PHONE_RESET        = 32'd3000;
    localparam logic [31:0] LINGERING_RESET    = 32'd10000;

    // field widths and stream packing
    localparam int INDEX_W      = 6;
    localparam int INDEX_COUNT  = 64;
    localparam int CFG_DATA_W   = 32;
    localparam int IN_TDATA_W   = 40;
    localparam int IN_TUSER_W   = 3;
    localparam int OUT_TDATA_W  = 40;
    localparam int FIELD_TIME_W = 32;

    // control part of one item, as seen by the update logic
    typedef struct packed {
        logic       op;
        logic [1:0] kind;
        logic       cond;
        logic       obs;
    } teaq_item_t;

endpackage

@@ rtl/timed_evidence_alarm_qualifier_top.sv @@
// Timed evidence alarm qualifier: a table of ENTRY_COUNT evidence entries, each
// debounced into normal, candidate or alert with a release hold. One item is
// taken per clock cycle unless the m_ side stalls; its result passes the input
// stage register, then the result register (entry read at the transfer, then
// update and write-back). The rate is set by the single entry memory, whose
// read and write ports each serve one item a cycle; the last write-back is
// forwarded to the next item so that back-to-back items on the same entry see
// fresh state. After reset a clearing pass writes every entry to its reset
// state, during which s_tready stays low; configuration writes are taken at
// all times and should only be made while no item is in flight.
module timed_evidence_alarm_qualifier_top
    import teaq_pkg::*;
#(
    parameter int ENTRY_COUNT = 64,
    parameter int TIME_BITS   = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    // entry_index[5:0], condition_true[6], is_observed[7], time_ms[39:8]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // operation[0], threshold_kind[2:1]
    input  logic [IN_TUSER_W-1:0]  s_tuser,

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // risk_level[1:0], active_ms[33:2], zero[39:34]
    output logic [OUT_TDATA_W-1:0] m_tdata,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int ADDR_W  = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int ENTRY_W = 3 * TIME_BITS + 3;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;

    logic [31:0] release_hold_reg;
    logic [31:0] multi_person_reg;
    logic [31:0] phone_reg;
    logic [31:0] lingering_reg;

    logic                  s1_valid_reg;
    teaq_item_t            s1_item_reg;
    logic [ADDR_W-1:0]     s1_addr_reg;
    logic [TIME_BITS-1:0]  s1_time_reg;

    logic                  fwd_valid_reg;
    logic [ADDR_W-1:0]     fwd_addr_reg;
    logic [ENTRY_W-1:0]    fwd_data_reg;

    logic                  m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;

    logic [ADDR_W-1:0] idx_tab [INDEX_COUNT];

    logic               s_accept;
    logic               s1_advance;
    logic [ADDR_W-1:0]  in_addr;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [ENTRY_W-1:0] cur_entry;
    logic [ENTRY_W-1:0] new_entry;
    logic [31:0]        threshold;

    logic [1:0]           new_level;
    logic [TIME_BITS-1:0] new_active;
    logic [TIME_BITS-1:0] new_last_ev;
    logic [TIME_BITS-1:0] new_last_pos;
    logic                 new_has_last;
    logic [1:0]           res_level;

    // entry index folded onto the table depth
    for (genvar i = 0; i < INDEX_COUNT; i++) begin : g_idx
        assign idx_tab[i] = ADDR_W'(i % ENTRY_COUNT);
    end

    assign in_addr = idx_tab[s_tdata[INDEX_W-1:0]];

    // clearing pass after reset
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(ENTRY_COUNT - 1)) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                clr_cnt_next = clr_cnt_reg;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            release_hold_reg <= RELEASE_HOLD_RESET;
            multi_person_reg <= MULTI_PERSON_RESET;
            phone_reg        <= PHONE_RESET;
            lingering_reg    <= LINGERING_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_RELEASE_HOLD: release_hold_reg <= cfg_data;
                CFG_MULTI_PERSON: multi_person_reg <= cfg_data;
                CFG_PHONE:        phone_reg        <= cfg_data;
                CFG_LINGERING:    lingering_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // handshake and pipeline control
    assign s1_advance = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready   = (state_reg == ST_RUN) && (!s1_valid_reg || s1_advance);
    assign s_accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_item_reg.op   <= s_tuser[0];
            s1_item_reg.kind <= s_tuser[2:1];
            s1_item_reg.cond <= s_tdata[6];
            s1_item_reg.obs  <= s_tdata[7];
            s1_addr_reg      <= in_addr;
            s1_time_reg      <= TIME_BITS'(s_tdata[8 +: FIELD_TIME_W]);
        end
    end

    // entry memory
    assign ram_we    = (state_reg == ST_CLEAR) || s1_advance;
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : s1_addr_reg;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : new_entry;

    teaq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRY_COUNT)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (s_accept),
        .rd_addr (in_addr),
        .rd_data (ram_rdata)
    );

    // the write-back made at the read edge is not yet in the read data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= new_entry;
        end
    end

    assign cur_entry = (fwd_valid_reg && fwd_addr_reg == s1_addr_reg) ? fwd_data_reg
                                                                        : ram_rdata;

    always_comb begin
        unique case (s1_item_reg.kind)
            KIND_MULTI_PERSON: threshold = multi_person_reg;
            KIND_PHONE:        threshold = phone_reg;
            default:           threshold = lingering_reg;
        endcase
    end

    teaq_update #(
        .TIME_BITS (TIME_BITS)
    ) u_update (
        .item         (s1_item_reg),
        .now          (s1_time_reg),
        .release_hold (release_hold_reg),
        .threshold    (threshold),
        .cur_level    (cur_entry[1:0]),
        .cur_active   (cur_entry[2 +: TIME_BITS]),
        .cur_last_ev  (cur_entry[2 + TIME_BITS +: TIME_BITS]),
        .cur_last_pos (cur_entry[2 + 2 * TIME_BITS +: TIME_BITS]),
        .cur_has_last (cur_entry[ENTRY_W-1]),
        .new_level    (new_level),
        .new_active   (new_active),
        .new_last_ev  (new_last_ev),
        .new_last_pos (new_last_pos),
        .new_has_last (new_has_last),
        .res_level    (res_level)
    );

    assign new_entry = {new_has_last, new_last_pos, new_last_ev, new_active, new_level};

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            m_data_reg <= {(OUT_TDATA_W - 2 - FIELD_TIME_W)'(0),
                           FIELD_TIME_W'(new_active), res_level};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

@@ rtl/teaq_ram.sv @@
// generic single-port-write, registered-read memory
module teaq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/teaq_update.sv @@
// per-item update of one evidence entry: accumulation, thresholds and hold
module teaq_update
    import teaq_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  teaq_item_t             item,
    input  logic [TIME_BITS-1:0]   now,
    input  logic [31:0]            release_hold,
    input  logic [31:0]            threshold,
    input  logic [1:0]             cur_level,
    input  logic [TIME_BITS-1:0]   cur_active,
    input  logic [TIME_BITS-1:0]   cur_last_ev,
    input  logic [TIME_BITS-1:0]   cur_last_pos,
    input  logic                   cur_has_last,
    output logic [1:0]             new_level,
    output logic [TIME_BITS-1:0]   new_active,
    output logic [TIME_BITS-1:0]   new_last_ev,
    output logic [TIME_BITS-1:0]   new_last_pos,
    output logic                   new_has_last,
    output logic [1:0]             res_level
);

    localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;

    logic [TIME_BITS-1:0] elapsed_ev;
    logic [TIME_BITS-1:0] elapsed_pos;
    logic [TIME_BITS:0]   sum;
    logic [TIME_BITS-1:0] acc;
    logic                 hold_over;
    logic                 reached;

    // time running backwards counts as no time at all
    assign elapsed_ev  = (now >= cur_last_ev)  ? now - cur_last_ev  : '0;
    assign elapsed_pos = (now >= cur_last_pos) ? now - cur_last_pos : '0;

    assign sum = {1'b0, cur_active} + {1'b0, elapsed_ev};
    assign acc = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];

    assign hold_over = CMP_W'(elapsed_pos) > CMP_W'(release_hold);
    assign reached   = CMP_W'(cur_has_last ? acc : cur_active) >= CMP_W'(threshold);

    always_comb begin
        new_level    = cur_level;
        new_active   = cur_active;
        new_last_ev  = cur_last_ev;
        new_last_pos = cur_last_pos;
        new_has_last = cur_has_last;
        res_level    = cur_level;
        if (item.op == OP_CLEAR) begin
            new_level    = LVL_NORMAL;
            new_active   = '0;
            new_last_ev  = '0;
            new_last_pos = '0;
            new_has_last = 1'b0;
            res_level    = LVL_NORMAL;
        end else if (!item.obs) begin
            new_has_last = 1'b0;
            if (cur_level == LVL_ALERT && hold_over) begin
                new_level  = LVL_NORMAL;
                new_active = '0;
                res_level  = LVL_NORMAL;
            end
        end else if (item.cond) begin
            if (cur_has_last) begin
                new_active = acc;
            end
            new_last_ev  = now;
            new_last_pos = now;
            new_has_last = 1'b1;
            new_level    = reached ? LVL_ALERT : LVL_CANDIDATE;
            res_level    = new_level;
        end else begin
            new_has_last = 1'b0;
            new_active   = '0;
            if (cur_level == LVL_ALERT && !hold_over) begin
                res_level = LVL_ALERT;
            end else begin
                new_level = LVL_NORMAL;
                res_level = LVL_NORMAL;
            end
        end
    end

endmodule

@@ rtl/teaq_checker.sv @@
// port-level checks of the alarm qualifier, bound to the top level
module teaq_checker
    import teaq_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // a stalled result transfer keeps its data
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // the clearing pass blocks input right after reset
    a_clear_blocks: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input taken during clearing pass");

    // no level code beyond alert
    a_level_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("invalid risk level");

    // an entry only returns to normal with its active time cleared
    a_normal_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == LVL_NORMAL |-> m_tdata[33:2] == 32'd0)
        else $error("normal level with active time");

endmodule

bind timed_evidence_alarm_qualifier_top teaq_checker u_teaq_checker (.*);
